>>> sv/bqcaf_pkg.sv
// Shared widths and payload types of the bowtie quad center/area/frame unit.
`default_nettype none

package bqcaf_pkg;

   localparam int COORD_W = 32;   // vertex coordinate
   localparam int DIFF_W  = 33;   // coordinate difference
   localparam int PROD_W  = 66;   // product of two differences
   localparam int DET_W   = 67;   // determinant and numerators
   localparam int NUM_W   = 101;  // divider dividend
   localparam int DIV_W   = 68;   // divider divisor and partial remainder
   localparam int QUO_W   = 33;   // divider quotient
   localparam int TPROD_W = 65;   // coordinate times difference
   localparam int TRI_W   = 67;   // doubled signed triangle area
   localparam int ASUM_W  = 68;   // sum of two doubled areas
   localparam int AREA_W  = 63;   // area result

   localparam int NPAIR      = 2;
   localparam int PAIR_AB_CD = 0;
   localparam int PAIR_BC_DA = 1;

   typedef struct packed {
      logic signed [COORD_W-1:0] ax;
      logic signed [COORD_W-1:0] ay;
      logic signed [COORD_W-1:0] bx;
      logic signed [COORD_W-1:0] by;
      logic signed [COORD_W-1:0] cx;
      logic signed [COORD_W-1:0] cy;
      logic signed [COORD_W-1:0] dx;
      logic signed [COORD_W-1:0] dy;
      logic signed [COORD_W-1:0] mnx;
      logic signed [COORD_W-1:0] mxx;
      logic signed [COORD_W-1:0] mny;
      logic signed [COORD_W-1:0] mxy;
   } base_type;

   typedef struct packed {
      logic signed [DIFF_W-1:0] x12;
      logic signed [DIFF_W-1:0] y12;
      logic signed [DIFF_W-1:0] x34;
      logic signed [DIFF_W-1:0] y34;
      logic signed [DIFF_W-1:0] x13;
      logic signed [DIFF_W-1:0] y13;
   } pdiff_type;

   typedef struct packed {
      logic signed [PROD_W-1:0] da;
      logic signed [PROD_W-1:0] db;
      logic signed [PROD_W-1:0] ta;
      logic signed [PROD_W-1:0] tb;
      logic signed [PROD_W-1:0] ua;
      logic signed [PROD_W-1:0] ub;
   } pprod_type;

   typedef struct packed {
      logic signed [DET_W-1:0] den;
      logic signed [DET_W-1:0] tn;
      logic signed [DET_W-1:0] un;
   } pdet_type;

   typedef struct packed {
      base_type                  base;
      logic                      found;
      logic                      first;
      logic                      negx;
      logic                      negy;
      logic signed [COORD_W-1:0] p1x;
      logic signed [COORD_W-1:0] p1y;
   } pay_type;

   typedef struct packed {
      logic                      found;
      logic signed [COORD_W-1:0] cenx;
      logic signed [COORD_W-1:0] ceny;
      logic signed [COORD_W-1:0] mnx;
      logic signed [COORD_W-1:0] mxx;
      logic signed [COORD_W-1:0] mny;
      logic signed [COORD_W-1:0] mxy;
   } post_type;

endpackage

`default_nettype wire

>>> sv/bqcaf_div.sv
// Pipelined restoring divider, one quotient bit per stage.
`default_nettype none

module bqcaf_div (
   input  logic                           clock,
   input  logic [bqcaf_pkg::NUM_W-1:0]    dividend,
   input  logic [bqcaf_pkg::DIV_W-1:0]    divisor,
   output logic [bqcaf_pkg::QUO_W-1:0]    quotient
);
   import bqcaf_pkg::*;

   logic [DIV_W-1:0] rem_ff [QUO_W-1];
   logic [DIV_W-1:0] rem_in [QUO_W-1];
   logic [DIV_W-1:0] dsr_ff [QUO_W-1];
   logic [DIV_W-1:0] dsr_in [QUO_W-1];
   logic [QUO_W-1:0] low_ff [QUO_W-1];
   logic [QUO_W-1:0] low_in [QUO_W-1];
   logic [QUO_W-1:0] quo_ff [QUO_W];
   logic [QUO_W-1:0] quo_in [QUO_W];

   logic [DIV_W-1:0] rem_sin [QUO_W];
   logic [DIV_W-1:0] dsr_sin [QUO_W];
   logic [QUO_W-1:0] low_sin [QUO_W];
   logic [QUO_W-1:0] quo_sin [QUO_W];

   // stage inputs: the ports for the first stage, the previous stage after that
   always_comb begin
      rem_sin[0] = dividend[NUM_W-1:QUO_W];
      dsr_sin[0] = divisor;
      low_sin[0] = dividend[QUO_W-1:0];
      quo_sin[0] = '0;
      for (int k = 1; k < QUO_W; k++) begin
         rem_sin[k] = rem_ff[k-1];
         dsr_sin[k] = dsr_ff[k-1];
         low_sin[k] = low_ff[k-1];
         quo_sin[k] = quo_ff[k-1];
      end
   end

   // shift in the next dividend bit, subtract when it fits
   always_comb begin
      logic [DIV_W:0] trial;
      logic           fits;
      for (int k = 0; k < QUO_W; k++) begin
         trial     = {rem_sin[k], low_sin[k][QUO_W-1]};
         fits      = (trial >= {1'b0, dsr_sin[k]});
         quo_in[k] = {quo_sin[k][QUO_W-2:0], fits};
         if (k < QUO_W - 1) begin
            rem_in[k] = fits ? DIV_W'(trial - {1'b0, dsr_sin[k]}) : trial[DIV_W-1:0];
            dsr_in[k] = dsr_sin[k];
            low_in[k] = {low_sin[k][QUO_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < QUO_W - 1; k++) begin
         rem_ff[k] <= rem_in[k];
         dsr_ff[k] <= dsr_in[k];
         low_ff[k] <= low_in[k];
      end
      for (int k = 0; k < QUO_W; k++) begin
         quo_ff[k] <= quo_in[k];
      end
   end

   assign quotient = quo_ff[QUO_W-1];

endmodule

`default_nettype wire

>>> sv/bowtie_quad_center_area_frame_unit.sv
// Top level of the bowtie quad unit: crossing point, bowtie area and bounding frame.
`default_nettype none

// Takes one quadrilateral A, B, C, D (signed fixed point, COORD_FRAC_BITS
// fraction bits) per cycle when start is high and busy is low, and returns
// one result word for each, marked by rsp_strobe for one cycle.
// The receiver cannot stall, so nothing is ever held back: busy is high only
// during reset. Sustained rate is one word per cycle; the pipeline is the
// 33-stage quotient divider (one quotient bit per stage) plus 8 stages of
// determinant work before it and 6 stages of area work after it.
// The unit looks for the crossing of AB and CD, else of BC and DA. A
// determinant within the parallel limit means no crossing. Without a crossing
// the center reads (0,0) and rsp_crossing_found is low. Area saturates.
module bowtie_quad_center_area_frame_unit #(
   parameter int COORD_FRAC_BITS = 16
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    start,
   output logic                                    busy,
   input  logic signed [bqcaf_pkg::COORD_W-1:0]    req_ax,
   input  logic signed [bqcaf_pkg::COORD_W-1:0]    req_ay,
   input  logic signed [bqcaf_pkg::COORD_W-1:0]    req_bx,
   input  logic signed [bqcaf_pkg::COORD_W-1:0]    req_by_coord,
   input  logic signed [bqcaf_pkg::COORD_W-1:0]    req_cx,
   input  logic signed [bqcaf_pkg::COORD_W-1:0]    req_cy,
   input  logic signed [bqcaf_pkg::COORD_W-1:0]    req_dxv,
   input  logic signed [bqcaf_pkg::COORD_W-1:0]    req_dyv,
   output logic                                    rsp_strobe,
   output logic                                    rsp_crossing_found,
   output logic signed [bqcaf_pkg::COORD_W-1:0]    rsp_center_x,
   output logic signed [bqcaf_pkg::COORD_W-1:0]    rsp_center_y,
   output logic        [bqcaf_pkg::AREA_W-1:0]     rsp_area,
   output logic        [bqcaf_pkg::COORD_W-1:0]    rsp_frame_width,
   output logic        [bqcaf_pkg::COORD_W-1:0]    rsp_frame_height,
   output logic signed [bqcaf_pkg::COORD_W-1:0]    rsp_frame_mid_x,
   output logic signed [bqcaf_pkg::COORD_W-1:0]    rsp_frame_mid_y
);
   import bqcaf_pkg::*;

   // determinants at or below this raw magnitude count as parallel
   localparam logic [DET_W-1:0] PAR_LIMIT =
      DET_W'((64'd1 << (2 * COORD_FRAC_BITS)) / 64'd1000000000);
   // area scaling to Q31.32: left shift, or right shift with round half up
   localparam int AREA_SHIFT = 31 - 2 * COORD_FRAC_BITS;
   localparam int SHL        = (AREA_SHIFT >= 0) ? AREA_SHIFT : 0;
   localparam int SHR        = (AREA_SHIFT < 0) ? -AREA_SHIFT : 0;
   localparam int AWK        = ASUM_W + SHL + 1;
   localparam logic [AWK-1:0] AREA_RND = (AWK'(1) << SHR) >> 1;
   localparam int PLO_W = 66;
   localparam int PHI_W = 67;

   function automatic logic signed [DIFF_W-1:0] sxt(input logic signed [COORD_W-1:0] v);
      return DIFF_W'(v);
   endfunction

   logic acc;

   // stage 1: register vertices, frame extremes, pair differences
   logic                 v1_ff, v1_in;
   base_type             base1_ff, base1_in;
   pdiff_type            dif1_ff [NPAIR];
   pdiff_type            dif1_in [NPAIR];
   // stage 2: products
   logic                 v2_ff, v2_in;
   base_type             base2_ff, base2_in;
   pprod_type            prd2_ff [NPAIR];
   pprod_type            prd2_in [NPAIR];
   // stage 3: determinant and numerators
   logic                 v3_ff, v3_in;
   base_type             base3_ff, base3_in;
   pdet_type             det3_ff [NPAIR];
   pdet_type             det3_in [NPAIR];
   // stage 4: sign-normalized, parallel test
   logic                 v4_ff, v4_in;
   base_type             base4_ff, base4_in;
   pdet_type             det4_ff [NPAIR];
   pdet_type             det4_in [NPAIR];
   logic [NPAIR-1:0]     par4_ff, par4_in;
   // stage 5: bounds test, pair select
   logic                 v5_ff, v5_in;
   pay_type              pay5_ff, pay5_in;
   logic [DET_W-1:0]     tn5_ff, tn5_in;
   logic [DET_W-1:0]     den5_ff, den5_in;
   logic [DIFF_W-1:0]    magx5_ff, magx5_in;
   logic [DIFF_W-1:0]    magy5_ff, magy5_in;
   // stage 6: partial products of t numerator and segment offset
   logic                 v6_ff, v6_in;
   pay_type              pay6_ff, pay6_in;
   logic [DET_W-1:0]     den6_ff, den6_in;
   logic [PLO_W-1:0]     plox6_ff, plox6_in, ploy6_ff, ploy6_in;
   logic [PHI_W-1:0]     phix6_ff, phix6_in, phiy6_ff, phiy6_in;
   // stage 7: full products
   logic                 v7_ff, v7_in;
   pay_type              pay7_ff, pay7_in;
   logic [DET_W-1:0]     den7_ff, den7_in;
   logic [NUM_W-1:0]     numx7_ff, numx7_in, numy7_ff, numy7_in;
   // stage 8: rounded dividends and doubled divisor
   logic                 v8_ff, v8_in;
   pay_type              pay8_ff, pay8_in;
   logic [NUM_W-1:0]     nx8_ff, nx8_in, ny8_ff, ny8_in;
   logic [DIV_W-1:0]     dsr8_ff, dsr8_in;
   // divider stages
   logic [QUO_W-1:0]     vd_ff, vd_in;
   pay_type              payd_ff [QUO_W];
   pay_type              payd_in [QUO_W];
   logic [QUO_W-1:0]     qx, qy;
   // area stage 1: center, triangle operands
   logic                 va1_ff, va1_in;
   post_type             post1_ff, post1_in;
   logic signed [COORD_W-1:0] tx1_ff [6];
   logic signed [COORD_W-1:0] tx1_in [6];
   logic signed [DIFF_W-1:0]  ty1_ff [6];
   logic signed [DIFF_W-1:0]  ty1_in [6];
   // area stage 2: products
   logic                 va2_ff, va2_in;
   post_type             post2_ff, post2_in;
   logic signed [TPROD_W-1:0] m2_ff [6];
   logic signed [TPROD_W-1:0] m2_in [6];
   // area stage 3: signed doubled areas
   logic                 va3_ff, va3_in;
   post_type             post3_ff, post3_in;
   logic signed [TRI_W-1:0] su3_ff, su3_in, sv3_ff, sv3_in;
   // area stage 4: magnitudes
   logic                 va4_ff, va4_in;
   post_type             post4_ff, post4_in;
   logic [TRI_W-1:0]     au4_ff, au4_in, av4_ff, av4_in;
   // area stage 5: sum
   logic                 va5_ff, va5_in;
   post_type             post5_ff, post5_in;
   logic [ASUM_W-1:0]    sum5_ff, sum5_in;
   // output register
   logic                 strobe_ff, strobe_in;
   logic                 found_ff, found_in;
   logic [COORD_W-1:0]   cenx_ff, cenx_in, ceny_ff, ceny_in;
   logic [AREA_W-1:0]    area_ff, area_in;
   logic [COORD_W-1:0]   fw_ff, fw_in, fh_ff, fh_in, fmx_ff, fmx_in, fmy_ff, fmy_in;

   // take a word whenever start is high outside reset
   assign busy = reset;
   assign acc  = start && !busy;

   // stage 1: frame extremes and differences for both segment pairs
   always_comb begin
      logic signed [COORD_W-1:0] lo_ab, lo_cd, hi_ab, hi_cd;
      v1_in       = acc;
      base1_in.ax = req_ax;
      base1_in.ay = req_ay;
      base1_in.bx = req_bx;
      base1_in.by = req_by_coord;
      base1_in.cx = req_cx;
      base1_in.cy = req_cy;
      base1_in.dx = req_dxv;
      base1_in.dy = req_dyv;
      lo_ab = (req_ax < req_bx) ? req_ax : req_bx;
      lo_cd = (req_cx < req_dxv) ? req_cx : req_dxv;
      hi_ab = (req_ax > req_bx) ? req_ax : req_bx;
      hi_cd = (req_cx > req_dxv) ? req_cx : req_dxv;
      base1_in.mnx = (lo_ab < lo_cd) ? lo_ab : lo_cd;
      base1_in.mxx = (hi_ab > hi_cd) ? hi_ab : hi_cd;
      lo_ab = (req_ay < req_by_coord) ? req_ay : req_by_coord;
      lo_cd = (req_cy < req_dyv) ? req_cy : req_dyv;
      hi_ab = (req_ay > req_by_coord) ? req_ay : req_by_coord;
      hi_cd = (req_cy > req_dyv) ? req_cy : req_dyv;
      base1_in.mny = (lo_ab < lo_cd) ? lo_ab : lo_cd;
      base1_in.mxy = (hi_ab > hi_cd) ? hi_ab : hi_cd;
      // AB against CD
      dif1_in[PAIR_AB_CD].x12 = sxt(req_ax) - sxt(req_bx);
      dif1_in[PAIR_AB_CD].y12 = sxt(req_ay) - sxt(req_by_coord);
      dif1_in[PAIR_AB_CD].x34 = sxt(req_cx) - sxt(req_dxv);
      dif1_in[PAIR_AB_CD].y34 = sxt(req_cy) - sxt(req_dyv);
      dif1_in[PAIR_AB_CD].x13 = sxt(req_ax) - sxt(req_cx);
      dif1_in[PAIR_AB_CD].y13 = sxt(req_ay) - sxt(req_cy);
      // BC against DA
      dif1_in[PAIR_BC_DA].x12 = sxt(req_bx) - sxt(req_cx);
      dif1_in[PAIR_BC_DA].y12 = sxt(req_by_coord) - sxt(req_cy);
      dif1_in[PAIR_BC_DA].x34 = sxt(req_dxv) - sxt(req_ax);
      dif1_in[PAIR_BC_DA].y34 = sxt(req_dyv) - sxt(req_ay);
      dif1_in[PAIR_BC_DA].x13 = sxt(req_bx) - sxt(req_dxv);
      dif1_in[PAIR_BC_DA].y13 = sxt(req_by_coord) - sxt(req_dyv);
   end

   // stage 2: six products per pair
   always_comb begin
      v2_in    = v1_ff;
      base2_in = base1_ff;
      for (int p = 0; p < NPAIR; p++) begin
         prd2_in[p].da = $signed(dif1_ff[p].x12) * $signed(dif1_ff[p].y34);
         prd2_in[p].db = $signed(dif1_ff[p].y12) * $signed(dif1_ff[p].x34);
         prd2_in[p].ta = $signed(dif1_ff[p].x13) * $signed(dif1_ff[p].y34);
         prd2_in[p].tb = $signed(dif1_ff[p].y13) * $signed(dif1_ff[p].x34);
         prd2_in[p].ua = $signed(dif1_ff[p].x13) * $signed(dif1_ff[p].y12);
         prd2_in[p].ub = $signed(dif1_ff[p].y13) * $signed(dif1_ff[p].x12);
      end
   end

   // stage 3: determinant, t and u numerators
   always_comb begin
      v3_in    = v2_ff;
      base3_in = base2_ff;
      for (int p = 0; p < NPAIR; p++) begin
         det3_in[p].den = DET_W'($signed(prd2_ff[p].da)) - DET_W'($signed(prd2_ff[p].db));
         det3_in[p].tn  = DET_W'($signed(prd2_ff[p].ta)) - DET_W'($signed(prd2_ff[p].tb));
         det3_in[p].un  = DET_W'($signed(prd2_ff[p].ua)) - DET_W'($signed(prd2_ff[p].ub));
      end
   end

   // stage 4: make the determinant positive, flag near-parallel pairs
   always_comb begin
      logic neg;
      v4_in    = v3_ff;
      base4_in = base3_ff;
      for (int p = 0; p < NPAIR; p++) begin
         neg = det3_ff[p].den[DET_W-1];
         det4_in[p].den = neg ? -det3_ff[p].den : det3_ff[p].den;
         det4_in[p].tn  = neg ? -det3_ff[p].tn  : det3_ff[p].tn;
         det4_in[p].un  = neg ? -det3_ff[p].un  : det3_ff[p].un;
         par4_in[p]     = ($unsigned(det4_in[p].den) <= PAR_LIMIT);
      end
   end

   // stage 5: both parameters in [0,1]; pick the first pair that crosses
   always_comb begin
      logic [NPAIR-1:0]           ok;
      logic                       sel;
      logic signed [COORD_W-1:0]  p1x, p1y, p2x, p2y;
      logic signed [DIFF_W-1:0]   ddx, ddy;
      for (int p = 0; p < NPAIR; p++) begin
         ok[p] = !par4_ff[p]
              && !det4_ff[p].tn[DET_W-1] && ($signed(det4_ff[p].tn) <= $signed(det4_ff[p].den))
              && !det4_ff[p].un[DET_W-1] && ($signed(det4_ff[p].un) <= $signed(det4_ff[p].den));
      end
      sel = !ok[PAIR_AB_CD];
      p1x = sel ? base4_ff.bx : base4_ff.ax;
      p1y = sel ? base4_ff.by : base4_ff.ay;
      p2x = sel ? base4_ff.cx : base4_ff.bx;
      p2y = sel ? base4_ff.cy : base4_ff.by;
      ddx = sxt(p2x) - sxt(p1x);
      ddy = sxt(p2y) - sxt(p1y);
      v5_in          = v4_ff;
      pay5_in.base   = base4_ff;
      pay5_in.first  = ok[PAIR_AB_CD];
      pay5_in.found  = ok[PAIR_AB_CD] || ok[PAIR_BC_DA];
      pay5_in.negx   = ddx[DIFF_W-1];
      pay5_in.negy   = ddy[DIFF_W-1];
      pay5_in.p1x    = p1x;
      pay5_in.p1y    = p1y;
      magx5_in       = ddx[DIFF_W-1] ? $unsigned(-ddx) : $unsigned(ddx);
      magy5_in       = ddy[DIFF_W-1] ? $unsigned(-ddy) : $unsigned(ddy);
      tn5_in         = sel ? det4_ff[PAIR_BC_DA].tn  : det4_ff[PAIR_AB_CD].tn;
      den5_in        = sel ? det4_ff[PAIR_BC_DA].den : det4_ff[PAIR_AB_CD].den;
   end

   // stage 6: split t numerator times offset into two partial products
   always_comb begin
      v6_in    = v5_ff;
      pay6_in  = pay5_ff;
      den6_in  = den5_ff;
      plox6_in = tn5_ff[DIFF_W-1:0] * magx5_ff;
      phix6_in = tn5_ff[DET_W-1:DIFF_W] * magx5_ff;
      ploy6_in = tn5_ff[DIFF_W-1:0] * magy5_ff;
      phiy6_in = tn5_ff[DET_W-1:DIFF_W] * magy5_ff;
   end

   // stage 7: merge partial products
   always_comb begin
      v7_in    = v6_ff;
      pay7_in  = pay6_ff;
      den7_in  = den6_ff;
      numx7_in = (NUM_W'(phix6_ff) << DIFF_W) + NUM_W'(plox6_ff);
      numy7_in = (NUM_W'(phiy6_ff) << DIFF_W) + NUM_W'(ploy6_ff);
   end

   // stage 8: round to nearest by dividing (2*num + den) by 2*den
   always_comb begin
      v8_in   = v7_ff;
      pay8_in = pay7_ff;
      nx8_in  = (numx7_ff << 1) + NUM_W'(den7_ff);
      ny8_in  = (numy7_ff << 1) + NUM_W'(den7_ff);
      dsr8_in = {den7_ff, 1'b0};
   end

   bqcaf_div u_div_x (
      .clock    (clock),
      .dividend (nx8_ff),
      .divisor  (dsr8_ff),
      .quotient (qx)
   );

   bqcaf_div u_div_y (
      .clock    (clock),
      .dividend (ny8_ff),
      .divisor  (dsr8_ff),
      .quotient (qy)
   );

   // carry valid and side payload alongside the divider stages
   always_comb begin
      vd_in      = {vd_ff[QUO_W-2:0], v8_ff};
      payd_in[0] = pay8_ff;
      for (int k = 1; k < QUO_W; k++) begin
         payd_in[k] = payd_ff[k-1];
      end
   end

   // area stage 1: apply the rounded offset, choose the two triangles
   always_comb begin
      pay_type                   pd;
      logic signed [DIFF_W:0]    offx, offy, sumx, sumy;
      logic signed [COORD_W-1:0] px, py;
      logic signed [COORD_W-1:0] ux [3];
      logic signed [COORD_W-1:0] uy [3];
      logic signed [COORD_W-1:0] wx [3];
      logic signed [COORD_W-1:0] wy [3];
      pd   = payd_ff[QUO_W-1];
      offx = pd.negx ? -$signed({1'b0, qx}) : $signed({1'b0, qx});
      offy = pd.negy ? -$signed({1'b0, qy}) : $signed({1'b0, qy});
      sumx = (DIFF_W + 1)'(pd.p1x) + offx;
      sumy = (DIFF_W + 1)'(pd.p1y) + offy;
      px   = pd.found ? sumx[COORD_W-1:0] : '0;
      py   = pd.found ? sumy[COORD_W-1:0] : '0;
      if (pd.first) begin
         // triangles A,P,D and B,C,P
         ux[0] = pd.base.ax; uy[0] = pd.base.ay;
         ux[1] = px;         uy[1] = py;
         ux[2] = pd.base.dx; uy[2] = pd.base.dy;
         wx[0] = pd.base.bx; wy[0] = pd.base.by;
         wx[1] = pd.base.cx; wy[1] = pd.base.cy;
         wx[2] = px;         wy[2] = py;
      end else begin
         // triangles P,C,D and P,A,B
         ux[0] = px;         uy[0] = py;
         ux[1] = pd.base.cx; uy[1] = pd.base.cy;
         ux[2] = pd.base.dx; uy[2] = pd.base.dy;
         wx[0] = px;         wy[0] = py;
         wx[1] = pd.base.ax; wy[1] = pd.base.ay;
         wx[2] = pd.base.bx; wy[2] = pd.base.by;
      end
      for (int i = 0; i < 3; i++) begin
         tx1_in[i]     = ux[i];
         tx1_in[i + 3] = wx[i];
         ty1_in[i]     = sxt(uy[(i + 1) % 3]) - sxt(uy[(i + 2) % 3]);
         ty1_in[i + 3] = sxt(wy[(i + 1) % 3]) - sxt(wy[(i + 2) % 3]);
      end
      va1_in        = vd_ff[QUO_W-1];
      post1_in.found = pd.found;
      post1_in.cenx  = px;
      post1_in.ceny  = py;
      post1_in.mnx   = pd.base.mnx;
      post1_in.mxx   = pd.base.mxx;
      post1_in.mny   = pd.base.mny;
      post1_in.mxy   = pd.base.mxy;
   end

   // area stage 2: shoelace products
   always_comb begin
      va2_in   = va1_ff;
      post2_in = post1_ff;
      for (int i = 0; i < 6; i++) begin
         m2_in[i] = tx1_ff[i] * ty1_ff[i];
      end
   end

   // area stage 3: signed doubled areas
   always_comb begin
      va3_in   = va2_ff;
      post3_in = post2_ff;
      su3_in   = TRI_W'(m2_ff[0]) + TRI_W'(m2_ff[1]) + TRI_W'(m2_ff[2]);
      sv3_in   = TRI_W'(m2_ff[3]) + TRI_W'(m2_ff[4]) + TRI_W'(m2_ff[5]);
   end

   // area stage 4: drop the orientation
   always_comb begin
      va4_in   = va3_ff;
      post4_in = post3_ff;
      au4_in   = su3_ff[TRI_W-1] ? $unsigned(-su3_ff) : $unsigned(su3_ff);
      av4_in   = sv3_ff[TRI_W-1] ? $unsigned(-sv3_ff) : $unsigned(sv3_ff);
   end

   // area stage 5: add the two triangles
   always_comb begin
      va5_in   = va4_ff;
      post5_in = post4_ff;
      sum5_in  = ASUM_W'(au4_ff) + ASUM_W'(av4_ff);
   end

   // output: scale area to Q31.32 and saturate, finish the frame
   always_comb begin
      logic [AWK-1:0]          scaled;
      logic signed [DIFF_W-1:0] msx, msy;
      scaled    = ((AWK'(sum5_ff) + AREA_RND) << SHL) >> SHR;
      area_in   = (|scaled[AWK-1:AREA_W]) ? {AREA_W{1'b1}} : scaled[AREA_W-1:0];
      strobe_in = va5_ff;
      found_in  = post5_ff.found;
      cenx_in   = post5_ff.cenx;
      ceny_in   = post5_ff.ceny;
      fw_in     = post5_ff.mxx - post5_ff.mnx;
      fh_in     = post5_ff.mxy - post5_ff.mny;
      msx       = sxt(post5_ff.mnx) + sxt(post5_ff.mxx);
      msy       = sxt(post5_ff.mny) + sxt(post5_ff.mxy);
      fmx_in    = msx[DIFF_W-1:1];
      fmy_in    = msy[DIFF_W-1:1];
   end

   // valid bits: cleared by reset
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff     <= 1'b0;
         v2_ff     <= 1'b0;
         v3_ff     <= 1'b0;
         v4_ff     <= 1'b0;
         v5_ff     <= 1'b0;
         v6_ff     <= 1'b0;
         v7_ff     <= 1'b0;
         v8_ff     <= 1'b0;
         vd_ff     <= '0;
         va1_ff    <= 1'b0;
         va2_ff    <= 1'b0;
         va3_ff    <= 1'b0;
         va4_ff    <= 1'b0;
         va5_ff    <= 1'b0;
         strobe_ff <= 1'b0;
      end else begin
         v1_ff     <= v1_in;
         v2_ff     <= v2_in;
         v3_ff     <= v3_in;
         v4_ff     <= v4_in;
         v5_ff     <= v5_in;
         v6_ff     <= v6_in;
         v7_ff     <= v7_in;
         v8_ff     <= v8_in;
         vd_ff     <= vd_in;
         va1_ff    <= va1_in;
         va2_ff    <= va2_in;
         va3_ff    <= va3_in;
         va4_ff    <= va4_in;
         va5_ff    <= va5_in;
         strobe_ff <= strobe_in;
      end
   end

   // payload: advance every cycle
   always_ff @(posedge clock) begin
      base1_ff <= base1_in;
      base2_ff <= base2_in;
      base3_ff <= base3_in;
      base4_ff <= base4_in;
      for (int p = 0; p < NPAIR; p++) begin
         dif1_ff[p] <= dif1_in[p];
         prd2_ff[p] <= prd2_in[p];
         det3_ff[p] <= det3_in[p];
         det4_ff[p] <= det4_in[p];
      end
      par4_ff  <= par4_in;
      pay5_ff  <= pay5_in;
      tn5_ff   <= tn5_in;
      den5_ff  <= den5_in;
      magx5_ff <= magx5_in;
      magy5_ff <= magy5_in;
      pay6_ff  <= pay6_in;
      den6_ff  <= den6_in;
      plox6_ff <= plox6_in;
      phix6_ff <= phix6_in;
      ploy6_ff <= ploy6_in;
      phiy6_ff <= phiy6_in;
      pay7_ff  <= pay7_in;
      den7_ff  <= den7_in;
      numx7_ff <= numx7_in;
      numy7_ff <= numy7_in;
      pay8_ff  <= pay8_in;
      nx8_ff   <= nx8_in;
      ny8_ff   <= ny8_in;
      dsr8_ff  <= dsr8_in;
      for (int k = 0; k < QUO_W; k++) begin
         payd_ff[k] <= payd_in[k];
      end
      post1_ff <= post1_in;
      for (int i = 0; i < 6; i++) begin
         tx1_ff[i] <= tx1_in[i];
         ty1_ff[i] <= ty1_in[i];
         m2_ff[i]  <= m2_in[i];
      end
      post2_ff <= post2_in;
      post3_ff <= post3_in;
      su3_ff   <= su3_in;
      sv3_ff   <= sv3_in;
      post4_ff <= post4_in;
      au4_ff   <= au4_in;
      av4_ff   <= av4_in;
      post5_ff <= post5_in;
      sum5_ff  <= sum5_in;
      found_ff <= found_in;
      cenx_ff  <= cenx_in;
      ceny_ff  <= ceny_in;
      area_ff  <= area_in;
      fw_ff    <= fw_in;
      fh_ff    <= fh_in;
      fmx_ff   <= fmx_in;
      fmy_ff   <= fmy_in;
   end

   assign rsp_strobe         = strobe_ff;
   assign rsp_crossing_found = found_ff;
   assign rsp_center_x       = cenx_ff;
   assign rsp_center_y       = ceny_ff;
   assign rsp_area           = area_ff;
   assign rsp_frame_width    = fw_ff;
   assign rsp_frame_height   = fh_ff;
   assign rsp_frame_mid_x    = fmx_ff;
   assign rsp_frame_mid_y    = fmy_ff;

`ifndef NO_ASSERTIONS
   localparam int LATENCY = 8 + QUO_W + 6;

   // every result word goes back to an accepted request a fixed time earlier
   a_latency : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start && !busy, LATENCY))
      else $error("result word without a matching request");

   a_no_cross_center : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_crossing_found |-> rsp_center_x == '0 && rsp_center_y == '0)
      else $error("center not zero without crossing");

   // a crossing lies on a quad edge, so it stays inside the frame
   a_center_in_frame : assert property (@(posedge clock) disable iff (reset)
      va1_ff && post1_ff.found |->
         $signed(post1_ff.mnx) <= $signed(post1_ff.cenx)
         && $signed(post1_ff.cenx) <= $signed(post1_ff.mxx)
         && $signed(post1_ff.mny) <= $signed(post1_ff.ceny)
         && $signed(post1_ff.ceny) <= $signed(post1_ff.mxy))
      else $error("crossing point outside frame");

   a_found_den : assert property (@(posedge clock) disable iff (reset)
      v5_ff && pay5_ff.found |-> den5_ff > PAR_LIMIT)
      else $error("crossing taken from a parallel pair");
`endif

endmodule

`default_nettype wire
